FILE: rtl/ilid_pkg.sv
// Shared types and codes for the indexed list store.
// Used by ilid_cell and indexed_list_insert_delete; no dependencies.
package ilid_pkg;

    localparam int DATA_W     = 32;
    localparam int MODE_W     = 3;
    localparam int POS_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int CAPACITY_DEF = 64;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INS_IDX  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [DATA_W-1:0] value;
    } ctl_t;

endpackage

FILE: rtl/ilid_cell.sv
// One slot of the shifting element chain.
// Depends on ilid_pkg for ctl_t and DATA_W.
module ilid_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7
) (
    input  logic                       aclk,
    input  ilid_pkg::ctl_t             ctl,
    input  logic [PW-1:0]              pos,
    input  logic [ilid_pkg::DATA_W-1:0] left_data,
    input  logic [ilid_pkg::DATA_W-1:0] right_data,
    output logic [ilid_pkg::DATA_W-1:0] data,
    output logic [ilid_pkg::DATA_W-1:0] hit_data
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [ilid_pkg::DATA_W-1:0] data_reg;
    logic [ilid_pkg::DATA_W-1:0] data_next;
    logic                        at_pos;
    logic                        past_pos;

    assign at_pos   = (pos == MY_IDX);
    assign past_pos = (MY_IDX > pos);

    // insert: slots past the gap take the left neighbor; delete: slots from pos take the right
    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (at_pos) begin
                data_next = ctl.value;
            end else if (past_pos) begin
                data_next = left_data;
            end
        end else if (ctl.del) begin
            if (at_pos || past_pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // masked value for the read OR-reduction
    assign hit_data = at_pos ? data_reg : '0;

endmodule

FILE: rtl/indexed_list_insert_delete.sv
// Top level of the indexed list store: control, count and output stage.
// Depends on ilid_pkg and ilid_cell.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata; each carries mode,
//   position and value. Every accepted item gives exactly one result on
//   m_tvalid/m_tready/m_tdata with read_value, status and the new count.
//   The elements live in a row of CAPACITY cells; an insert or delete moves
//   every affected cell by one slot in the same cycle, and the result is
//   registered; an item can be taken every cycle while the receiver does
//   not stall, set by the single broadcast step of the cell row.
//   A read selects the addressed cell through an OR-reduction of masked
//   cell outputs.
//   Reset (aresetn low at a clock edge) empties the list and drops any
//   pending result; cell contents are not cleared and are never shown.
//   When the receiver stalls, the result register holds and s_tready stays
//   low until the result is taken; a new item is accepted in the same cycle
//   that the waiting result leaves.
module indexed_list_insert_delete #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] mode, [9:3] position, [41:10] value, [47:42] zero
    input  logic [ilid_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] read_value, [33:32] status, [40:34] count, [47:41] zero
    output logic [ilid_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (CNT_W > ilid_pkg::POS_W) ? CNT_W : ilid_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam int DW    = ilid_pkg::DATA_W;

    logic [ilid_pkg::MODE_W-1:0]   mode;
    logic [ilid_pkg::POS_W-1:0]    position;
    logic [DW-1:0]                 value;

    logic                          s_accept;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [PW-1:0]                 cnt_next_ext;
    logic [PW-1:0]                 pos_ext;
    logic [PW-1:0]                 cnt_ext;
    logic [PW-1:0]                 op_pos;
    logic                          full;
    logic                          do_ins;
    logic                          do_del;
    logic                          do_read;
    logic [ilid_pkg::STATUS_W-1:0] status;
    logic [DW-1:0]                 read_value;
    ilid_pkg::ctl_t                ctl;

    logic                          m_valid_reg;
    logic [DW-1:0]                 m_rd_reg;
    logic [ilid_pkg::STATUS_W-1:0] m_status_reg;
    logic [ilid_pkg::COUNT_W-1:0]  m_count_reg;

    logic [DW-1:0] cell_data [CAPACITY];
    logic [DW-1:0] hit_data  [CAPACITY];
    logic [DW-1:0] rd_or;

    // field unpacking
    assign mode     = s_tdata[2:0];
    assign position = s_tdata[9:3];
    assign value    = s_tdata[41:10];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(cnt_reg);
    assign full    = (cnt_reg == CAP_CNT);

    // decode the operation and check range / capacity
    always_comb begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_read = 1'b0;
        op_pos  = pos_ext;
        status  = ilid_pkg::ST_OK;
        unique case (mode)
            ilid_pkg::MODE_READ: begin
                if (pos_ext < cnt_ext) do_read = 1'b1;
                else                   status  = ilid_pkg::ST_RANGE;
            end
            ilid_pkg::MODE_INS_HEAD: begin
                op_pos = '0;
                if (full) status = ilid_pkg::ST_FULL;
                else      do_ins = 1'b1;
            end
            ilid_pkg::MODE_INS_TAIL: begin
                op_pos = cnt_ext;
                if (full) status = ilid_pkg::ST_FULL;
                else      do_ins = 1'b1;
            end
            ilid_pkg::MODE_INS_IDX: begin
                if (pos_ext > cnt_ext) status = ilid_pkg::ST_RANGE;
                else if (full)         status = ilid_pkg::ST_FULL;
                else                   do_ins = 1'b1;
            end
            ilid_pkg::MODE_DELETE: begin
                if (pos_ext < cnt_ext) do_del = 1'b1;
                else                   status = ilid_pkg::ST_RANGE;
            end
            default: begin
            end
        endcase
    end

    assign ctl.ins   = do_ins && s_accept;
    assign ctl.del   = do_del && s_accept;
    assign ctl.value = value;

    // count update
    always_comb begin
        cnt_next = cnt_reg;
        if (do_ins)      cnt_next = cnt_reg + CNT_W'(1);
        else if (do_del) cnt_next = cnt_reg - CNT_W'(1);
    end

    // widened so the reported count slice always exists
    assign cnt_next_ext = PW'(cnt_next);

    // the cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DW-1:0] left_d;
        logic [DW-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = value;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        ilid_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .pos        (op_pos),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit_data   (hit_data[i])
        );
    end

    // one-hot read select
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | hit_data[k];
        end
    end

    assign read_value = do_read ? rd_or : '1;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                cnt_reg <= cnt_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_rd_reg     <= read_value;
            m_status_reg <= status;
            m_count_reg  <= cnt_next_ext[ilid_pkg::COUNT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_status_reg, m_rd_reg};

    // count never passes the capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP_CNT)
        else $error("element count above capacity");

    // every accepted item leaves a result
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted item gave no result");

    // a pending result reports the current count
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_count_reg == cnt_ext[ilid_pkg::COUNT_W-1:0]))
        else $error("reported count differs from stored count");

    // a full status only arises when the store is full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && status == ilid_pkg::ST_FULL) |-> full)
        else $error("full status with free slots");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for indexed_list_insert_delete: directed table, then random traffic.
// Its predictor keeps its own copy of the list and checks every result in order.
// Depends on ilid_pkg and the RTL of the list store.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP        = ilid_pkg::CAPACITY_DEF;
    localparam int TOTAL_ITEMS     = 750;
    localparam int RX_HOLD_CYCLES  = 80;
    localparam int WATCHDOG_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_REPORTS     = 10;

    localparam int MW = ilid_pkg::MODE_W;
    localparam int PW = ilid_pkg::POS_W;
    localparam int DW = ilid_pkg::DATA_W;
    localparam int SW = ilid_pkg::STATUS_W;
    localparam int CW = ilid_pkg::COUNT_W;

    // Mode codes that the block treats as no-ops
    localparam logic [MW-1:0] MODE_NOP_FIRST = 3'd5;
    localparam logic [MW-1:0] MODE_NOP_MID   = 3'd6;
    localparam logic [MW-1:0] MODE_NOP_LAST  = 3'd7;

    localparam logic [DW-1:0] VAL_NONE = 32'hFFFF_FFFF;
    localparam logic [DW-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] VAL_MIN  = 32'h8000_0000;

    // Operation mix of one random episode
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_FILL} mix_t;

    typedef struct packed {
        logic [DW-1:0] rd;
        logic [SW-1:0] st;
        logic [CW-1:0] cnt;
    } list_result_t;

    typedef struct {
        logic [MW-1:0] mode;
        logic [PW-1:0] pos;
        logic [DW-1:0] value;
        bit            typed;
        list_result_t  res;
    } dir_row_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // [2:0] mode, [9:3] position, [41:10] value, [47:42] zero
    logic [ilid_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // [31:0] read_value, [33:32] status, [40:34] count, [47:41] zero
    logic [ilid_pkg::M_TDATA_W-1:0] m_tdata;

    // Predicted list contents and length
    logic [DW-1:0] list_mem [LIST_CAP];
    int            list_len = 0;

    list_result_t pending_q [$];
    dir_row_t     dir_rows  [$];

    int  n_fail        = 0;
    int  n_checked     = 0;
    int  n_sent        = 0;
    int  n_ok          = 0;
    int  n_range       = 0;
    int  n_full        = 0;
    int  peak_len      = 0;
    int  rx_holds_done = 0;
    bit  calm          = 1'b0;
    bit  rx_hold_req   = 1'b0;

    indexed_list_insert_delete #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Apply one operation to the predicted list and return its result
    function automatic list_result_t list_apply(input logic [MW-1:0] mode,
                                                input logic [PW-1:0] pos,
                                                input logic [DW-1:0] value);
        list_result_t r;
        int           p;
        int           i;
        bit           do_ins;
        r.rd   = VAL_NONE;
        r.st   = ilid_pkg::ST_OK;
        p      = int'(pos);
        do_ins = 1'b0;
        case (mode)
            ilid_pkg::MODE_READ: begin
                if (p < list_len) r.rd = list_mem[p];
                else r.st = ilid_pkg::ST_RANGE;
            end
            ilid_pkg::MODE_INS_HEAD: begin
                p = 0;
                if (list_len >= LIST_CAP) r.st = ilid_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            ilid_pkg::MODE_INS_TAIL: begin
                p = list_len;
                if (list_len >= LIST_CAP) r.st = ilid_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            ilid_pkg::MODE_INS_IDX: begin
                // range check comes before the full check
                if (p > list_len) r.st = ilid_pkg::ST_RANGE;
                else if (list_len >= LIST_CAP) r.st = ilid_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            ilid_pkg::MODE_DELETE: begin
                if (p < list_len) begin
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
                    list_len--;
                end else begin
                    r.st = ilid_pkg::ST_RANGE;
                end
            end
            default: ;
        endcase
        if (do_ins) begin
            for (i = list_len; i > p; i--) list_mem[i] = list_mem[i - 1];
            list_mem[p] = value;
            list_len++;
        end
        r.cnt = CW'(list_len);
        return r;
    endfunction

    task automatic add_row(input logic [MW-1:0] mode, input logic [PW-1:0] pos,
                           input logic [DW-1:0] value, input bit typed,
                           input logic [DW-1:0] rd, input logic [SW-1:0] st,
                           input int cnt);
        dir_row_t row;
        row.mode   = mode;
        row.pos    = pos;
        row.value  = value;
        row.typed  = typed;
        row.res.rd  = rd;
        row.res.st  = st;
        row.res.cnt = CW'(cnt);
        dir_rows.push_back(row);
    endtask

    // Offer one item after a random gap, then log its expected result once accepted
    task automatic send_item(input logic [MW-1:0] mode, input logic [PW-1:0] pos,
                             input logic [DW-1:0] value, input bit typed,
                             input list_result_t typed_res);
        int           gap;
        list_result_t want;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ilid_pkg::S_TDATA_W - 42){1'b0}}, value, pos, mode};
        do @(posedge aclk); while (!s_tready);
        want = list_apply(mode, pos, value);
        if (typed) want = typed_res;
        pending_q.push_back(want);
        n_sent++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    // Random item shaped by the episode mix: mostly valid positions, some anywhere
    task automatic send_random(input mix_t mix);
        logic [MW-1:0] mode;
        logic [PW-1:0] pos;
        logic [DW-1:0] value;
        int            pick;
        int            ins_w;
        int            del_w;
        case (mix)
            MIX_GROW:   begin ins_w = 65;  del_w = 15; end
            MIX_SHRINK: begin ins_w = 15;  del_w = 65; end
            MIX_FILL:   begin ins_w = 100; del_w = 0;  end
            default:    begin ins_w = 35;  del_w = 35; end
        endcase
        if ($urandom_range(0, 99) < 3) begin
            mode = MW'($urandom_range(int'(MODE_NOP_FIRST), int'(MODE_NOP_LAST)));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < ins_w)
                mode = MW'($urandom_range(int'(ilid_pkg::MODE_INS_HEAD),
                                          int'(ilid_pkg::MODE_INS_IDX)));
            else if (pick < ins_w + del_w)
                mode = ilid_pkg::MODE_DELETE;
            else
                mode = ilid_pkg::MODE_READ;
        end
        if ($urandom_range(0, 99) < 15)
            pos = PW'($urandom_range(0, 127));
        else if (mode == ilid_pkg::MODE_INS_IDX)
            pos = PW'($urandom_range(0, list_len));
        else if (list_len > 0)
            pos = PW'($urandom_range(0, list_len - 1));
        else
            pos = PW'($urandom_range(0, 127));
        case ($urandom_range(0, 19))
            0:       value = VAL_MAX;
            1:       value = VAL_MIN;
            2:       value = VAL_NONE;
            3:       value = '0;
            default: value = $urandom;
        endcase
        send_item(mode, pos, value, 1'b0, '0);
    endtask

    // Drop tvalid and wait until every logged result has come back
    task automatic rest_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_q.size() != 0);
    endtask

    // Result sink: random ready gaps, plus one long hold-off on request
    initial begin : result_sink
        int wait_cycles;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
                rx_holds_done++;
            end
            wait_cycles = calm ? 0 : $urandom_range(0, 9);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each accepted result with the oldest logged one
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rd  = m_tdata[31:0];
            got.st  = m_tdata[33:32];
            got.cnt = m_tdata[40:34];
            n_checked++;
            case (got.st)
                ilid_pkg::ST_OK:    n_ok++;
                ilid_pkg::ST_RANGE: n_range++;
                ilid_pkg::ST_FULL:  n_full++;
                default:  ;
            endcase
            if (pending_q.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("unexpected result: rd=%h st=%0d cnt=%0d",
                             got.rd, got.st, got.cnt);
            end else begin
                want = pending_q.pop_front();
                if (got.rd !== want.rd || got.st !== want.st || got.cnt !== want.cnt) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("mismatch at result %0d: rd %h/%h st %0d/%0d cnt %0d/%0d",
                                 n_checked, got.rd, want.rd, got.st, want.st,
                                 got.cnt, want.cnt);
                end
            end
        end
    end

    // Watchdog: cycles in a row with no item moving on either side
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (!aresetn) @(posedge aclk);
        while (idle_cycles < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int   k;
        int   len;
        mix_t mix;

        // Directed table, starting from an empty list
        add_row(ilid_pkg::MODE_READ,     7'd0,   32'd0,   1, VAL_NONE, ilid_pkg::ST_RANGE, 0);
        add_row(ilid_pkg::MODE_DELETE,   7'd0,   32'd0,   1, VAL_NONE, ilid_pkg::ST_RANGE, 0);
        add_row(ilid_pkg::MODE_INS_IDX,  7'd1,   32'd5,   1, VAL_NONE, ilid_pkg::ST_RANGE, 0);
        add_row(ilid_pkg::MODE_INS_IDX,  7'd0,   VAL_MAX, 1, VAL_NONE, ilid_pkg::ST_OK,    1);
        add_row(ilid_pkg::MODE_INS_HEAD, 7'd0,   VAL_MIN, 1, VAL_NONE, ilid_pkg::ST_OK,    2);
        add_row(ilid_pkg::MODE_INS_TAIL, 7'd127, VAL_NONE, 1, VAL_NONE, ilid_pkg::ST_OK,   3);
        // index equal to count appends
        add_row(ilid_pkg::MODE_INS_IDX,  7'd3,   32'd0,   1, VAL_NONE, ilid_pkg::ST_OK,    4);
        add_row(ilid_pkg::MODE_INS_IDX,  7'd1,   32'h5A5A5A5A, 0, '0, '0, 0);
        add_row(ilid_pkg::MODE_READ,     7'd0,   32'd0,   1, VAL_MIN,  ilid_pkg::ST_OK,    5);
        add_row(ilid_pkg::MODE_READ,     7'd4,   VAL_NONE, 0, '0, '0, 0);
        add_row(ilid_pkg::MODE_READ,     7'd5,   32'd0,   1, VAL_NONE, ilid_pkg::ST_RANGE, 5);
        add_row(ilid_pkg::MODE_READ,     7'd127, 32'd0,   1, VAL_NONE, ilid_pkg::ST_RANGE, 5);
        add_row(ilid_pkg::MODE_INS_IDX,  7'd127, 32'd1,   1, VAL_NONE, ilid_pkg::ST_RANGE, 5);
        add_row(MODE_NOP_FIRST,          7'd0,   32'd0,   1, VAL_NONE, ilid_pkg::ST_OK,    5);
        add_row(MODE_NOP_LAST,           7'd127, VAL_NONE, 1, VAL_NONE, ilid_pkg::ST_OK,   5);
        add_row(MODE_NOP_MID,            7'd2,   32'h1234, 0, '0, '0, 0);
        add_row(ilid_pkg::MODE_DELETE,   7'd127, 32'd0,   1, VAL_NONE, ilid_pkg::ST_RANGE, 5);
        add_row(ilid_pkg::MODE_DELETE,   7'd2,   32'd0,   0, '0, '0, 0);
        add_row(ilid_pkg::MODE_READ,     7'd2,   32'd0,   0, '0, '0, 0);
        add_row(ilid_pkg::MODE_DELETE,   7'd3,   32'd0,   0, '0, '0, 0);
        add_row(ilid_pkg::MODE_DELETE,   7'd0,   32'd0,   0, '0, '0, 0);
        add_row(ilid_pkg::MODE_DELETE,   7'd0,   32'd0,   0, '0, '0, 0);
        // removing the only element leaves an empty list
        add_row(ilid_pkg::MODE_DELETE,   7'd0,   32'd0,   1, VAL_NONE, ilid_pkg::ST_OK,    0);
        add_row(ilid_pkg::MODE_READ,     7'd0,   32'd0,   1, VAL_NONE, ilid_pkg::ST_RANGE, 0);
        add_row(ilid_pkg::MODE_INS_HEAD, 7'd0,   32'h1234, 1, VAL_NONE, ilid_pkg::ST_OK,   1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < dir_rows.size(); k++)
            send_item(dir_rows[k].mode, dir_rows[k].pos, dir_rows[k].value,
                      dir_rows[k].typed, dir_rows[k].res);

        // Fill to capacity, then keep pushing into the full store
        while (list_len < LIST_CAP) send_random(MIX_FILL);
        repeat (8) send_random(MIX_FILL);

        // Receiver holds off while items keep coming back to back
        rx_hold_req = 1'b1;
        calm = 1'b1;
        repeat (24) send_random(MIX_MIXED);
        calm = 1'b0;
        rest_until_drained();

        // Random episodes of growth, shrinkage and mixed traffic
        while (n_sent < TOTAL_ITEMS) begin
            mix  = mix_t'($urandom_range(0, 2));
            calm = ($urandom_range(0, 3) == 0);
            len  = $urandom_range(30, 80);
            for (k = 0; k < len && n_sent < TOTAL_ITEMS; k++) send_random(mix);
        end
        calm = 1'b0;

        rest_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d results for %0d items, list peaked at %0d of %0d entries",
                 n_checked, n_sent, peak_len, LIST_CAP);
        $display("statuses: %0d ok, %0d out of range, %0d full; %0d long receiver hold-off(s)",
                 n_ok, n_range, n_full, rx_holds_done);
        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
